FILE: hw/rtl/coap_message_parser_defines.svh
// ---------------------------------------------------------------------------
// coap_message_parser_defines: assertion macros for the message parser
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COAP_MESSAGE_PARSER_DEFINES_SVH
`define COAP_MESSAGE_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define CMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define CMP_IMPLIES(label, ante, cons, msg) \
    `CMP_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/cmp_pkg.sv
// ---------------------------------------------------------------------------
// cmp_pkg: shared types and constants of the CoAP message parser
// Payload structs, event and status codes, parse phases, the request record
// that travels from the parser front to the event back, and the code check.
// ---------------------------------------------------------------------------
`default_nettype none

package cmp_pkg;

    // Depth of the queue between parser front and event back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] MAX_BYTES_RESET = 16'd1152;

    // Option extension offsets
    localparam logic [16:0] EXT8_OFFSET  = 17'd13;
    localparam logic [16:0] EXT16_OFFSET = 17'd269;
    localparam logic [3:0]  NIB_EXT8     = 4'hD;
    localparam logic [3:0]  NIB_EXT16    = 4'hE;
    localparam logic [3:0]  NIB_RESERVED = 4'hF;
    localparam logic [1:0]  COAP_VERSION = 2'd1;
    localparam logic [3:0]  MAX_TOKEN_LEN = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BYTES    = 2'd0,
        CFG_CHECK_CODES  = 2'd1,
        CFG_ACCEPT_EMPTY = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_HEADER  = 3'd0,
        EV_TOKEN   = 3'd1,
        EV_OPTION  = 3'd2,
        EV_VALUE   = 3'd3,
        EV_PAYLOAD = 3'd4,
        EV_END     = 3'd5
    } ev_kind_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_VERSION     = 4'd2,
        ST_TOKEN_LEN   = 4'd3,
        ST_CODE        = 4'd4,
        ST_TOKEN_TRUNC = 4'd5,
        ST_NIBBLE_15   = 4'd6,
        ST_OPT_TRUNC   = 4'd7,
        ST_TOO_LONG    = 4'd8,
        ST_NUM_OVF     = 4'd9
    } status_t;

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_HDR2    = 4'd2,
        PH_HDR3    = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_DEXT8   = 4'd6,
        PH_DEXT16H = 4'd7,
        PH_DEXT16L = 4'd8,
        PH_LEXT8   = 4'd9,
        PH_LEXT16H = 4'd10,
        PH_LEXT16L = 4'd11,
        PH_VALUE   = 4'd12,
        PH_PAYLOAD = 4'd13,
        PH_DRAIN   = 4'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [2:0]  code_class;
        logic [4:0]  code_detail;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  data_out;
        logic [3:0]  status;
        logic        end_flag;
    } out_item_t;

    // Header as latched so far
    typedef struct packed {
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [2:0]  code_class;
        logic [4:0]  code_detail;
        logic [15:0] message_id;
    } hdr_t;

    // One accepted byte: an optional byte event and an optional end event
    typedef struct packed {
        logic        has_ev;
        ev_kind_t    ev_kind;
        logic [15:0] ev_num;
        logic [16:0] ev_len;
        logic [7:0]  ev_data;
        logic        has_end;
        status_t     end_status;
        hdr_t        hdr;
    } step_rec_t;

    // Code registry check; code 0.00 always follows the empty-code switch
    function automatic logic code_allowed(input logic [2:0] cls, input logic [4:0] det,
                                          input logic check, input logic empty_ok);
        logic ok;
        if (cls == 3'd0 && det == 5'd0) begin
            ok = empty_ok;
        end else if (!check) begin
            ok = 1'b1;
        end else begin
            case (cls)
                3'd0:    ok = (det <= 5'd4);
                3'd2:    ok = (det >= 5'd1) && (det <= 5'd5);
                3'd4:    ok = (det <= 5'd6) || (det == 5'd12) || (det == 5'd13)
                              || (det == 5'd15);
                3'd5:    ok = (det <= 5'd5);
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cmp_front.sv
// ---------------------------------------------------------------------------
// cmp_front: byte parser of the CoAP message parser
// Holds the configuration registers and the parse state, takes one byte per
// cycle while in_accept is high, making a request record for the event queue.
// ---------------------------------------------------------------------------
`default_nettype none

module cmp_front (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write_en,
    input  wire [cmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [cmp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                           in_accept,
    input  cmp_pkg::in_item_t             in_item,
    output logic                          push,
    output cmp_pkg::step_rec_t            push_rec
);
    import cmp_pkg::*;

    logic [15:0] max_bytes_reg;
    logic        check_codes_reg;
    logic        accept_empty_reg;

    phase_t      phase_reg, phase_next, phase_proc;
    logic [15:0] byte_cnt_reg, byte_cnt_next, cnt_inc;
    hdr_t        hdr_reg, hdr_proc;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] last_num_reg, last_num_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  ext_hi_reg, ext_hi_next;
    status_t     err_reg, err_next, err_proc;

    logic [7:0]  b;
    logic [3:0]  d_nib, l_nib, pend_l;
    logic        last;
    logic        over_hit;
    logic [16:0] ext8, ext16, delta, opt_len;
    logic [17:0] sum18;
    logic        num_ovf, do_delta, len_direct, opt_fin, is_lext;
    status_t     end_st;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg    <= MAX_BYTES_RESET;
            check_codes_reg  <= 1'b1;
            accept_empty_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MAX_BYTES:    max_bytes_reg    <= cfg_data[15:0];
                CFG_CHECK_CODES:  check_codes_reg  <= cfg_data[0];
                CFG_ACCEPT_EMPTY: accept_empty_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Decode the incoming byte and the option arithmetic
    assign b        = in_item.data_in;
    assign last     = in_item.last_byte;
    assign d_nib    = b[7:4];
    assign l_nib    = b[3:0];
    assign over_hit = (byte_cnt_reg >= max_bytes_reg) && (phase_reg != PH_DRAIN);
    assign cnt_inc  = (byte_cnt_reg != 16'hFFFF) ? byte_cnt_reg + 16'd1 : byte_cnt_reg;
    assign ext8     = 17'(b) + EXT8_OFFSET;
    assign ext16    = 17'({ext_hi_reg, b}) + EXT16_OFFSET;
    assign pend_l   = (phase_reg == PH_OPT) ? l_nib : pend_reg[3:0];
    assign is_lext  = (phase_reg == PH_LEXT8) || (phase_reg == PH_LEXT16L);

    always_comb
    begin
        case (phase_reg)
            PH_DEXT8:   delta = ext8;
            PH_DEXT16L: delta = ext16;
            default:    delta = 17'(d_nib);
        endcase
        case (phase_reg)
            PH_LEXT8:   opt_len = ext8;
            PH_LEXT16L: opt_len = ext16;
            default:    opt_len = 17'(pend_l);
        endcase
    end

    assign sum18      = 18'(last_num_reg) + 18'(delta);
    assign num_ovf    = (sum18[17:16] != 2'd0);
    assign len_direct = (pend_l != NIB_EXT8) && (pend_l != NIB_EXT16);
    assign do_delta   = (phase_reg == PH_DEXT8) || (phase_reg == PH_DEXT16L)
                        || ((phase_reg == PH_OPT) && (d_nib < NIB_EXT8)
                            && (l_nib != NIB_RESERVED));
    assign opt_fin    = !over_hit && ((do_delta && !num_ovf && len_direct) || is_lext);

    // Next parse state and datapath registers
    always_comb
    begin
        phase_proc    = phase_reg;
        hdr_proc      = hdr_reg;
        rem_next      = rem_reg;
        last_num_next = last_num_reg;
        pend_next     = pend_reg;
        ext_hi_next   = ext_hi_reg;
        err_proc      = err_reg;
        byte_cnt_next = cnt_inc;

        if (over_hit)
        begin
            err_proc   = ST_TOO_LONG;
            phase_proc = PH_DRAIN;
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    hdr_proc           = '0;
                    hdr_proc.msg_type  = b[5:4];
                    hdr_proc.token_len = b[3:0];
                    if (b[7:6] != COAP_VERSION)
                    begin
                        err_proc   = ST_VERSION;
                        phase_proc = PH_DRAIN;
                    end
                    else if (b[3:0] > MAX_TOKEN_LEN)
                    begin
                        err_proc   = ST_TOKEN_LEN;
                        phase_proc = PH_DRAIN;
                    end
                    else
                    begin
                        phase_proc = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    hdr_proc.code_class  = b[7:5];
                    hdr_proc.code_detail = b[4:0];
                    if (!code_allowed(b[7:5], b[4:0], check_codes_reg, accept_empty_reg))
                    begin
                        err_proc   = ST_CODE;
                        phase_proc = PH_DRAIN;
                    end
                    else
                    begin
                        phase_proc = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    hdr_proc.message_id[15:8] = b;
                    phase_proc                = PH_HDR3;
                end
                PH_HDR3:
                begin
                    hdr_proc.message_id[7:0] = b;
                    rem_next   = 17'(hdr_reg.token_len);
                    phase_proc = (hdr_reg.token_len != 4'd0) ? PH_TOKEN : PH_OPT;
                end
                PH_TOKEN, PH_VALUE:
                begin
                    if (rem_reg != 17'd0)
                    begin
                        rem_next = rem_reg - 17'd1;
                    end
                    if (rem_reg <= 17'd1)
                    begin
                        phase_proc = PH_OPT;
                    end
                end
                PH_OPT:
                begin
                    if (d_nib == NIB_RESERVED && l_nib == NIB_RESERVED)
                    begin
                        phase_proc = PH_PAYLOAD;
                    end
                    else if (d_nib == NIB_RESERVED || l_nib == NIB_RESERVED)
                    begin
                        err_proc   = ST_NIBBLE_15;
                        phase_proc = PH_DRAIN;
                    end
                    else
                    begin
                        pend_next = b;
                        if (d_nib == NIB_EXT8)
                        begin
                            phase_proc = PH_DEXT8;
                        end
                        else if (d_nib == NIB_EXT16)
                        begin
                            phase_proc = PH_DEXT16H;
                        end
                    end
                end
                PH_DEXT16H, PH_LEXT16H:
                begin
                    ext_hi_next = b;
                    phase_proc  = (phase_reg == PH_DEXT16H) ? PH_DEXT16L : PH_LEXT16L;
                end
                default:
                begin
                end
            endcase

            // Apply an option delta, then open the length field
            if (do_delta)
            begin
                if (num_ovf)
                begin
                    err_proc   = ST_NUM_OVF;
                    phase_proc = PH_DRAIN;
                end
                else
                begin
                    last_num_next = sum18[15:0];
                    if (pend_l == NIB_EXT8)
                    begin
                        phase_proc = PH_LEXT8;
                    end
                    else if (pend_l == NIB_EXT16)
                    begin
                        phase_proc = PH_LEXT16H;
                    end
                end
            end

            // Close an option: enter its value or look for the next one
            if (opt_fin)
            begin
                if (opt_len != 17'd0)
                begin
                    rem_next   = opt_len;
                    phase_proc = PH_VALUE;
                end
                else
                begin
                    phase_proc = PH_OPT;
                end
            end
        end

        phase_next = phase_proc;
        err_next   = err_proc;
        if (last)
        begin
            phase_next    = PH_HDR0;
            byte_cnt_next = 16'd0;
            rem_next      = 17'd0;
            last_num_next = 16'd0;
            pend_next     = 8'd0;
            ext_hi_next   = 8'd0;
            err_next      = ST_OK;
        end
    end

    // End status from the phase left by this byte
    always_comb
    begin
        if (cnt_inc < 16'd4)
        begin
            end_st = ST_SHORT;
        end
        else
        begin
            unique case (phase_proc)
                PH_DRAIN:            end_st = err_proc;
                PH_TOKEN:            end_st = ST_TOKEN_TRUNC;
                PH_OPT, PH_PAYLOAD:  end_st = ST_OK;
                default:             end_st = ST_OPT_TRUNC;
            endcase
        end
    end

    // Build the request record for this byte
    always_comb
    begin
        push_rec            = '0;
        push_rec.hdr        = hdr_proc;
        push_rec.has_end    = last;
        push_rec.end_status = end_st;
        push_rec.ev_kind    = EV_HEADER;
        if (!over_hit)
        begin
            unique case (phase_reg)
                PH_HDR3:
                begin
                    push_rec.has_ev  = 1'b1;
                    push_rec.ev_kind = EV_HEADER;
                end
                PH_TOKEN:
                begin
                    push_rec.has_ev  = 1'b1;
                    push_rec.ev_kind = EV_TOKEN;
                    push_rec.ev_data = b;
                end
                PH_VALUE:
                begin
                    push_rec.has_ev  = 1'b1;
                    push_rec.ev_kind = EV_VALUE;
                    push_rec.ev_data = b;
                end
                PH_PAYLOAD:
                begin
                    push_rec.has_ev  = 1'b1;
                    push_rec.ev_kind = EV_PAYLOAD;
                    push_rec.ev_data = b;
                end
                default:
                begin
                end
            endcase
        end
        if (opt_fin)
        begin
            push_rec.has_ev  = 1'b1;
            push_rec.ev_kind = EV_OPTION;
            push_rec.ev_num  = is_lext ? last_num_reg : sum18[15:0];
            push_rec.ev_len  = opt_len;
        end
    end

    assign push = in_accept && (push_rec.has_ev || push_rec.has_end);

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            byte_cnt_reg <= 16'd0;
            hdr_reg      <= '0;
            rem_reg      <= 17'd0;
            last_num_reg <= 16'd0;
            pend_reg     <= 8'd0;
            ext_hi_reg   <= 8'd0;
            err_reg      <= ST_OK;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            byte_cnt_reg <= byte_cnt_next;
            hdr_reg      <= last ? '0 : hdr_proc;
            rem_reg      <= rem_next;
            last_num_reg <= last_num_next;
            pend_reg     <= pend_next;
            ext_hi_reg   <= ext_hi_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cmp_queue.sv
// ---------------------------------------------------------------------------
// cmp_queue: request queue between parser front and event back
// A small register FIFO of step records; the head is read in place.
// ---------------------------------------------------------------------------
`default_nettype none

module cmp_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  cmp_pkg::step_rec_t  push_rec,
    output logic                full,
    input  wire                 pop,
    output logic                head_valid,
    output cmp_pkg::step_rec_t  head_rec
);
    import cmp_pkg::*;

    step_rec_t         slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cmp_back.sv
// ---------------------------------------------------------------------------
// cmp_back: event back end of the CoAP message parser
// Expands each queued request into its byte event and end event and holds
// them one at a time in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cmp_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 head_valid,
    input  cmp_pkg::step_rec_t  head_rec,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output cmp_pkg::out_item_t  out_data
);
    import cmp_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic      ev_done_reg, ev_done_next;
    logic      load_ok;
    out_item_t ev_item, end_item;

    assign load_ok = !out_valid_reg || !out_stall;

    // Format the two possible events of the head request
    always_comb
    begin
        ev_item               = '0;
        ev_item.event_kind    = head_rec.ev_kind;
        ev_item.msg_type      = head_rec.hdr.msg_type;
        ev_item.token_len     = head_rec.hdr.token_len;
        ev_item.code_class    = head_rec.hdr.code_class;
        ev_item.code_detail   = head_rec.hdr.code_detail;
        ev_item.message_id    = head_rec.hdr.message_id;
        ev_item.option_number = head_rec.ev_num;
        ev_item.option_length = head_rec.ev_len;
        ev_item.data_out      = head_rec.ev_data;

        end_item               = '0;
        end_item.event_kind    = EV_END;
        end_item.msg_type      = head_rec.hdr.msg_type;
        end_item.token_len     = head_rec.hdr.token_len;
        end_item.code_class    = head_rec.hdr.code_class;
        end_item.code_detail   = head_rec.hdr.code_detail;
        end_item.message_id    = head_rec.hdr.message_id;
        end_item.status        = head_rec.end_status;
        end_item.end_flag      = 1'b1;
    end

    // Load the next event when the output register frees up
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ev_done_next   = ev_done_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (head_rec.has_ev && !ev_done_reg)
                begin
                    out_next     = ev_item;
                    pop          = !head_rec.has_end;
                    ev_done_next = head_rec.has_end;
                end
                else
                begin
                    out_next     = end_item;
                    pop          = 1'b1;
                    ev_done_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ev_done_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ev_done_reg   <= ev_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/coap_message_parser.sv
// ---------------------------------------------------------------------------
// coap_message_parser: streaming CoAP message parser, top level
// Byte parser front, request queue and event back end.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one message byte per
//   request, with last_byte set on the final byte of each message.
//   Output channel (out_valid / out_stall / out_data) gives the events: header,
//   token bytes, option headers, option value bytes, payload bytes and one end
//   event carrying the status.
//   Throughput: one byte per cycle while in_stall is low, set by the parse
//   step in the front; the output register moves one event per cycle while
//   out_stall is low, so a final byte that also has a byte event gives two
//   events, the byte event and then the end event. An event is registered
//   first in a queue slot and then in the output register before it appears.
//   The front and back are parted by a four-entry queue; when the receiver
//   stalls the queue fills and in_stall rises, and no event is lost.
//   Configuration writes on cfg_write_en / cfg_index / cfg_data take effect
//   on the next byte. Reset empties the queue, re-arms the parser at header
//   byte zero and restores max 1152 bytes, code checking on, empty code off.
// ---------------------------------------------------------------------------
`default_nettype none

module coap_message_parser (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write_en,
    input  wire [cmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [cmp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  cmp_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  wire                           out_stall,
    output cmp_pkg::out_item_t            out_data
);
    import cmp_pkg::*;

    logic      in_accept;
    logic      push, full, pop, head_valid;
    step_rec_t push_rec, head_rec;

    // Take a byte whenever the queue has room
    assign in_stall  = full;
    assign in_accept = in_valid && !full;

    cmp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .in_item      (in_data),
        .push         (push),
        .push_rec     (push_rec)
    );

    cmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    cmp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/coap_message_parser_checker.sv
// ---------------------------------------------------------------------------
// coap_message_parser_checker: port-level checks of the message parser
// Watches the output channel for held requests and consistent event fields.
// ---------------------------------------------------------------------------
`default_nettype none
`include "coap_message_parser_defines.svh"

module coap_message_parser_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           out_valid,
    input  wire                           out_stall,
    input  cmp_pkg::out_item_t            out_data
);
    import cmp_pkg::*;

    // A stalled event stays in place
    `CMP_ASSERT(a_out_hold,
                out_valid && out_stall |=> out_valid && $stable(out_data),
                "stalled event changed")

    // The end flag marks the end event and nothing else
    `CMP_IMPLIES(a_end_kind, out_valid,
                 out_data.end_flag == (out_data.event_kind == EV_END),
                 "end flag and kind disagree")

    // Only the end event carries a status
    `CMP_IMPLIES(a_status_end, out_valid && !out_data.end_flag,
                 out_data.status == ST_OK, "status on a non-end event")

    // Option fields are zero outside option headers
    `CMP_IMPLIES(a_opt_zero, out_valid && (out_data.event_kind != EV_OPTION),
                 (out_data.option_number == 16'd0) && (out_data.option_length == 17'd0),
                 "option fields set outside option event")

endmodule

bind coap_message_parser coap_message_parser_checker u_checker (.*);

`default_nettype wire
